[rtl/stack_machine_execute_unit_macros.svh]
// ----------------------------------------------------------------------------
// Stack machine execute unit assertion macros
// Shared property macros for the assertion checker, sampled on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMX_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smx check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smx check failed");

`endif

[rtl/smx_pkg.sv]
// ----------------------------------------------------------------------------
// Stack machine execute package
// Sizes, opcodes, status codes, state encodings and control structs shared
// by the execute unit, its iterative arithmetic unit and its checker.
// ----------------------------------------------------------------------------
package smx_pkg;

	// Storage sizes.
	localparam int STACK_DEPTH = 256;
	localparam int ADDR_BITS   = 16;
	localparam int MEM_WORDS   = 1 << ADDR_BITS;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Opcodes.
	localparam logic [7:0] OP_HALT  = 8'd0;
	localparam logic [7:0] OP_GET   = 8'd1;
	localparam logic [7:0] OP_SET   = 8'd2;
	localparam logic [7:0] OP_PUT   = 8'd3;
	localparam logic [7:0] OP_POP   = 8'd4;
	localparam logic [7:0] OP_CLEAR = 8'd6;
	localparam logic [7:0] OP_GETP  = 8'd7;
	localparam logic [7:0] OP_GOTO  = 8'd8;
	localparam logic [7:0] OP_GOTOS = 8'd9;
	localparam logic [7:0] OP_ADD   = 8'd10;
	localparam logic [7:0] OP_SUB   = 8'd11;
	localparam logic [7:0] OP_MULT  = 8'd12;
	localparam logic [7:0] OP_DIV   = 8'd13;
	localparam logic [7:0] OP_POW   = 8'd14;
	localparam logic [7:0] OP_ROOT  = 8'd15;
	localparam logic [7:0] OP_MOD   = 8'd16;
	localparam logic [7:0] OP_EQ    = 8'd17;
	localparam logic [7:0] OP_LT    = 8'd18;
	localparam logic [7:0] OP_GT    = 8'd19;
	localparam logic [7:0] OP_NOT   = 8'd20;
	localparam logic [7:0] OP_POS   = 8'd21;
	localparam logic [7:0] OP_SETP  = 8'd24;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_DIVZERO  = 3'd2;
	localparam logic [2:0] ST_ROOTZERO = 3'd3;
	localparam logic [2:0] ST_HALT     = 3'd4;

	// Execute sequencer states.
	typedef enum logic [2:0] {
		EX_CLEAR,
		EX_IDLE,
		EX_EXEC,
		EX_ITER,
		EX_FILL,
		EX_WB
	} ex_state_t;

	// Iterative unit operation kinds and states.
	typedef enum logic [1:0] {
		IT_DIV,
		IT_MOD,
		IT_POW,
		IT_ROOT
	} it_kind_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_DIV,
		U_RLAUNCH,
		U_POW,
		U_DONE
	} it_state_t;

	// Request to the iterative unit: lhs is the deeper operand, rhs the top.
	typedef struct packed {
		logic        start;
		it_kind_t    kind;
		logic [31:0] lhs;
		logic [31:0] rhs;
	} it_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} it_rsp_t;

endpackage

[rtl/stack_machine_execute_unit.sv]
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one stack machine instruction per input beat and returns one
// result beat with the next index, top of stack, depth and status.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the data memory to zero, one word a cycle,
// over all MEM_WORDS (65536) words, and holds in_stall high meanwhile. The
// operand stack and the data memory are single-read, single-write RAMs with
// a registered read; the top of stack is kept in a register. One instruction
// is worked on at a time: plain stack, memory and arithmetic instructions
// pass from input beat to result through accept with reads, execute and
// write back; indirect set adds a fill step for its extra stack read, and
// divide, modulo, power (one multiply a cycle) and root (a bit-by-bit
// search) iterate in the iterative unit before write back.
// The result waits in an output register, and the next input beat is
// taken while it waits.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
	import smx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       opcode,
	input  logic [15:0]      argument,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [15:0]      next_index,
	output logic [31:0]      top_value,
	output logic [CNT_W-1:0] stack_depth,
	output logic [2:0]       status
);

	ex_state_t state_q, state_d;

	logic [7:0]           op_q;
	logic [15:0]          arg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          top_q;
	logic [15:0]          idx_q;
	logic [ADDR_BITS-1:0] clr_q;

	logic [CNT_W-1:0] pc_q;
	logic             push_q;
	logic [31:0]      val_q;
	logic [2:0]       stat_q;
	logic [15:0]      nxt_q;
	logic [31:0]      tap_q;

	logic             out_valid_q;
	logic [15:0]      out_next_q;
	logic [31:0]      out_top_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [2:0]       out_stat_q;

	// Memory ports.
	logic                 s_we;
	logic [SP_W-1:0]      s_waddr;
	logic [SP_W-1:0]      s_raddr;
	logic [31:0]          s_rdata;
	logic                 m_we;
	logic [ADDR_BITS-1:0] m_waddr;
	logic [31:0]          m_wdata;
	logic [ADDR_BITS-1:0] m_raddr;
	logic [31:0]          m_rdata;

	// Execute decode.
	logic             has2;
	logic [31:0]      sec;
	logic [CNT_W-1:0] pc1;
	logic [CNT_W-1:0] pc2;
	logic [CNT_W-1:0] e_pc;
	logic             e_push;
	logic [31:0]      e_val;
	logic [2:0]       e_stat;
	logic [15:0]      e_next;
	logic [31:0]      e_tap;
	logic             e_iter;
	logic             e_fill;
	logic             e_mwe;
	logic [ADDR_BITS-1:0] e_maddr;
	logic [31:0]      mul_lo;
	it_req_t          ireq;
	it_rsp_t          irsp;

	// Write back.
	logic             in_fire;
	logic             out_free;
	logic             wb_fire;
	logic             ovf;
	logic [CNT_W-1:0] wb_cnt;
	logic [31:0]      wb_top;
	logic [2:0]       wb_stat;

	assign in_stall = (state_q != EX_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign wb_fire  = (state_q == EX_WB) && out_free;

	smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (val_q),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	smx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	smx_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ireq),
		.rsp    (irsp)
	);

	// Read addresses: second entry at accept, third entry during execute.
	always_comb begin
		if (state_q == EX_IDLE) begin
			s_raddr = SP_W'(cnt_q - CNT_W'(2));
		end else begin
			s_raddr = SP_W'(cnt_q - CNT_W'(3));
		end
		if (opcode == OP_GETP) begin
			m_raddr = ADDR_BITS'(top_q);
		end else begin
			m_raddr = ADDR_BITS'(argument);
		end
	end

	// Operands seen in the execute cycle; empty entries read as zero.
	assign has2   = (cnt_q >= CNT_W'(2));
	assign sec    = has2 ? s_rdata : 32'd0;
	assign pc1    = (cnt_q == CNT_W'(0)) ? CNT_W'(0) : cnt_q - CNT_W'(1);
	assign pc2    = has2 ? cnt_q - CNT_W'(2) : CNT_W'(0);
	assign mul_lo = sec * top_q;

	// Instruction decode and combinational datapath.
	always_comb begin
		e_pc    = cnt_q;
		e_push  = 1'b0;
		e_val   = 32'd0;
		e_stat  = ST_OK;
		e_next  = idx_q + 16'd1;
		e_tap   = top_q;
		e_iter  = 1'b0;
		e_fill  = 1'b0;
		e_mwe   = 1'b0;
		e_maddr = ADDR_BITS'(arg_q);
		ireq.kind = IT_DIV;
		unique case (op_q)
			OP_HALT: begin
				e_stat = ST_HALT;
				e_next = idx_q;
			end
			OP_GET: begin
				e_push = 1'b1;
				e_val  = m_rdata;
			end
			OP_SET: begin
				e_mwe = 1'b1;
			end
			OP_PUT: begin
				e_push = 1'b1;
				e_val  = {16'd0, arg_q};
			end
			OP_POP: begin
				e_pc  = pc1;
				e_tap = sec;
			end
			OP_CLEAR: begin
				e_pc  = CNT_W'(0);
				e_tap = 32'd0;
			end
			OP_GETP: begin
				e_pc   = pc1;
				e_push = 1'b1;
				e_val  = m_rdata;
			end
			OP_GOTO: begin
				e_pc  = CNT_W'(0);
				e_tap = 32'd0;
				if (top_q != 32'd0) begin
					e_next = arg_q;
				end
			end
			OP_GOTOS: begin
				e_pc  = CNT_W'(0);
				e_tap = 32'd0;
				if (sec != 32'd0) begin
					e_next = top_q[15:0];
				end
			end
			OP_ADD: begin
				e_pc   = pc2;
				e_push = 1'b1;
				e_val  = sec + top_q;
			end
			OP_SUB: begin
				e_pc   = pc2;
				e_push = 1'b1;
				e_val  = sec - top_q;
			end
			OP_MULT: begin
				e_pc   = pc2;
				e_push = 1'b1;
				e_val  = mul_lo;
			end
			OP_DIV, OP_MOD: begin
				e_pc      = pc2;
				e_push    = 1'b1;
				ireq.kind = (op_q == OP_MOD) ? IT_MOD : IT_DIV;
				if (top_q == 32'd0) begin
					e_stat = ST_DIVZERO;
				end else begin
					e_iter = 1'b1;
				end
			end
			OP_POW: begin
				e_pc      = pc2;
				e_push    = 1'b1;
				ireq.kind = IT_POW;
				e_iter    = 1'b1;
			end
			OP_ROOT: begin
				e_pc      = pc2;
				e_push    = 1'b1;
				ireq.kind = IT_ROOT;
				if (top_q == 32'd0) begin
					e_stat = ST_ROOTZERO;
				end else begin
					e_iter = 1'b1;
				end
			end
			OP_EQ: begin
				e_pc   = pc2;
				e_push = 1'b1;
				e_val  = {31'd0, top_q == sec};
			end
			OP_LT: begin
				e_pc   = pc2;
				e_push = 1'b1;
				e_val  = {31'd0, top_q < sec};
			end
			OP_GT: begin
				e_pc   = pc2;
				e_push = 1'b1;
				e_val  = {31'd0, top_q > sec};
			end
			OP_NOT: begin
				e_pc   = pc1;
				e_push = 1'b1;
				e_val  = {31'd0, top_q == 32'd0};
			end
			OP_POS: begin
				e_push = 1'b1;
				e_val  = {16'd0, idx_q};
			end
			OP_SETP: begin
				e_pc    = pc2;
				e_mwe   = 1'b1;
				e_maddr = ADDR_BITS'(sec);
				e_fill  = 1'b1;
			end
			default: begin
				e_pc = cnt_q;
			end
		endcase
		ireq.start = (state_q == EX_EXEC) && e_iter;
		ireq.lhs   = sec;
		ireq.rhs   = top_q;
	end

	// Data memory writes: the clearing sweep, then set and indirect set.
	always_comb begin
		if (state_q == EX_CLEAR) begin
			m_we    = 1'b1;
			m_waddr = clr_q;
			m_wdata = 32'd0;
		end else begin
			m_we    = (state_q == EX_EXEC) && e_mwe;
			m_waddr = e_maddr;
			m_wdata = top_q;
		end
	end

	// Write back: a push onto a full stack is dropped and flagged.
	assign ovf     = push_q && (pc_q == CNT_W'(STACK_DEPTH));
	assign wb_cnt  = (push_q && !ovf) ? pc_q + CNT_W'(1) : pc_q;
	assign wb_top  = (push_q && !ovf) ? val_q : tap_q;
	assign wb_stat = ovf ? ST_OVERFLOW : stat_q;
	assign s_we    = wb_fire && push_q && !ovf;
	assign s_waddr = SP_W'(pc_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_CLEAR: begin
				if (clr_q == {ADDR_BITS{1'b1}}) begin
					state_d = EX_IDLE;
				end
			end
			EX_IDLE: begin
				if (in_fire) begin
					state_d = EX_EXEC;
				end
			end
			EX_EXEC: begin
				if (e_iter) begin
					state_d = EX_ITER;
				end else if (e_fill) begin
					state_d = EX_FILL;
				end else begin
					state_d = EX_WB;
				end
			end
			EX_ITER: begin
				if (irsp.done) begin
					state_d = EX_WB;
				end
			end
			EX_FILL: state_d = EX_WB;
			EX_WB: begin
				if (out_free) begin
					state_d = EX_IDLE;
				end
			end
			default: state_d = EX_IDLE;
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EX_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			top_q       <= 32'd0;
			idx_q       <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == EX_CLEAR) begin
				clr_q <= clr_q + ADDR_BITS'(1);
			end
			if (wb_fire) begin
				cnt_q       <= wb_cnt;
				top_q       <= wb_top;
				idx_q       <= nxt_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Instruction and work registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= opcode;
			arg_q <= argument;
		end
		if (state_q == EX_EXEC) begin
			pc_q   <= e_pc;
			push_q <= e_push;
			val_q  <= e_val;
			stat_q <= e_stat;
			nxt_q  <= e_next;
			tap_q  <= e_tap;
		end
		if (state_q == EX_ITER && irsp.done) begin
			val_q <= irsp.result;
		end
		if (state_q == EX_FILL) begin
			tap_q <= (cnt_q >= CNT_W'(3)) ? s_rdata : 32'd0;
		end
		if (wb_fire) begin
			out_next_q <= nxt_q;
			out_top_q  <= wb_top;
			out_cnt_q  <= wb_cnt;
			out_stat_q <= wb_stat;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_index  = out_next_q;
	assign top_value   = out_top_q;
	assign stack_depth = out_cnt_q;
	assign status      = out_stat_q;

endmodule

[rtl/smx_ram.sv]
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/smx_iter.sv]
// ----------------------------------------------------------------------------
// Stack machine iterative arithmetic unit
// Restoring divide and modulo (one quotient bit a cycle), saturating power
// (one multiply a cycle) and floor root (bitwise search over power trials).
// ----------------------------------------------------------------------------
module smx_iter
	import smx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  it_req_t req,
	output it_rsp_t rsp
);

	it_state_t   st_q, st_d;
	it_kind_t    kind_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [31:0] xval_q;
	logic [4:0]  cnt_q;
	logic [31:0] base_q;
	logic [4:0]  exp_q;
	logic [31:0] acc_q;
	logic        sat_q;
	logic [15:0] res_q;
	logic [3:0]  bit_q;
	logic [31:0] out_q;

	// Divide step.
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;
	logic [31:0] rem_n;
	logic [31:0] quo_n;

	// Power launch and step.
	logic [31:0] l_base;
	logic [31:0] l_exp;
	logic [31:0] l_acc;
	logic        l_sat;
	logic [4:0]  l_cnt;
	logic [63:0] prod;
	logic [15:0] cand;
	logic        fit;
	logic [15:0] res_n;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = !diff[32];
	assign rem_n   = ge ? diff[31:0] : shifted[31:0];
	assign quo_n   = {quo_q[30:0], ge};

	assign cand  = res_q | (16'd1 << bit_q);
	assign prod  = {32'd0, acc_q} * {32'd0, base_q};
	assign fit   = !sat_q && (acc_q <= xval_q);
	assign res_n = fit ? cand : res_q;

	// Operands of a power trial: the request or the next root candidate.
	always_comb begin
		if (st_q == U_IDLE) begin
			l_base = req.lhs;
			l_exp  = req.rhs;
		end else begin
			l_base = {16'd0, cand};
			l_exp  = dsr_q;
		end
	end

	// Special powers finish at once; any other base of two or more saturates
	// for an exponent of 32 or more.
	always_comb begin
		l_acc = 32'd1;
		l_sat = 1'b0;
		l_cnt = 5'd0;
		priority if (l_exp == 32'd0) begin
			l_acc = 32'd1;
		end else if (l_base == 32'd0) begin
			l_acc = 32'd0;
		end else if (l_base == 32'd1) begin
			l_acc = 32'd1;
		end else if (|l_exp[31:5]) begin
			l_sat = 1'b1;
		end else begin
			l_cnt = l_exp[4:0];
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			U_IDLE: begin
				if (req.start) begin
					unique case (req.kind)
						IT_DIV, IT_MOD: st_d = U_DIV;
						IT_POW:         st_d = U_POW;
						IT_ROOT:        st_d = (req.rhs == 32'd1) ? U_DONE : U_RLAUNCH;
						default:        st_d = U_IDLE;
					endcase
				end
			end
			U_DIV:     st_d = (cnt_q == 5'd0) ? U_DONE : U_DIV;
			U_RLAUNCH: st_d = U_POW;
			U_POW: begin
				if (sat_q || exp_q == 5'd0) begin
					if (kind_q == IT_POW || bit_q == 4'd0) begin
						st_d = U_DONE;
					end else begin
						st_d = U_RLAUNCH;
					end
				end
			end
			U_DONE:  st_d = U_IDLE;
			default: st_d = U_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		rsp.done   = (st_q == U_DONE);
		rsp.result = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= U_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (st_q)
			U_IDLE: begin
				kind_q <= req.kind;
				quo_q  <= req.lhs;
				rem_q  <= 32'd0;
				dsr_q  <= req.rhs;
				xval_q <= req.lhs;
				cnt_q  <= 5'd31;
				res_q  <= 16'd0;
				bit_q  <= 4'd15;
				base_q <= l_base;
				acc_q  <= l_acc;
				sat_q  <= l_sat;
				exp_q  <= l_cnt;
				out_q  <= req.lhs;
			end
			U_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q - 5'd1;
				out_q <= (kind_q == IT_MOD) ? rem_n : quo_n;
			end
			U_RLAUNCH: begin
				base_q <= l_base;
				acc_q  <= l_acc;
				sat_q  <= l_sat;
				exp_q  <= l_cnt;
			end
			U_POW: begin
				if (sat_q || exp_q == 5'd0) begin
					if (kind_q == IT_POW) begin
						out_q <= sat_q ? 32'hFFFF_FFFF : acc_q;
					end else begin
						res_q <= res_n;
						bit_q <= bit_q - 4'd1;
						out_q <= {16'd0, res_n};
					end
				end else begin
					if (|prod[63:32]) begin
						sat_q <= 1'b1;
					end else begin
						acc_q <= prod[31:0];
					end
					exp_q <= exp_q - 5'd1;
				end
			end
			U_DONE: begin
				out_q <= out_q;
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

endmodule

[rtl/smx_checker.sv]
// ----------------------------------------------------------------------------
// Stack machine execute checker
// Port-level checks on the result channel of the execute unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_unit_macros.svh"

module smx_checker
	import smx_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [15:0]      next_index,
	input logic [31:0]      top_value,
	input logic [CNT_W-1:0] stack_depth,
	input logic [2:0]       status
);

	// A stalled result beat stays offered.
	`SMX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// An empty stack shows a zero top.
	`SMX_ASSERT_SAME(a_empty_top, out_valid && stack_depth == CNT_W'(0), top_value == 32'd0)

	// Overflow is only reported with a full stack.
	`SMX_ASSERT_SAME(a_ovf_full, out_valid && status == ST_OVERFLOW, stack_depth == CNT_W'(STACK_DEPTH))

	// Depth never exceeds the stack size.
	`SMX_ASSERT_SAME(a_depth_max, out_valid, stack_depth <= CNT_W'(STACK_DEPTH))

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (.*);
